// ===== design/adcsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the reciprocal table of the ADC smoothing filter.
// No dependencies; imported by the filter top level and its port checker.
package adcsf_pkg;

    localparam int CHANNELS  = 3;
    localparam int WINDOW    = 8;
    localparam int EMA_FRAC  = 16;
    localparam int SAMPLE_W  = 12;
    localparam int ALPHA_W   = 16;
    localparam int ALPHA_SH  = 15;
    localparam int POS_W     = $clog2(WINDOW);
    localparam int COUNT_W   = $clog2(WINDOW + 1);
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int STEP_W    = $clog2(CHANNELS + 1);
    localparam int SUM_W     = SAMPLE_W + POS_W;
    localparam int EMA_W     = SAMPLE_W + EMA_FRAC;
    localparam int PA_W      = ALPHA_W + SAMPLE_W;
    localparam int PL_W      = ALPHA_W + EMA_FRAC;
    localparam int PH_W      = ALPHA_W + SAMPLE_W;
    localparam int TOT_W     = ALPHA_W + EMA_W;
    localparam int RECIP_SH  = 20;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam int DIVP_W    = SUM_W + RECIP_W;

    localparam int S_TDATA_W = ((SAMPLE_W * CHANNELS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * SAMPLE_W * CHANNELS + 7) / 8) * 8;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 16'h8000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd3277;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [EMA_W-1:0] ema;
    } chan_entry_t;

    // ceil(2^RECIP_SH / d), exact truncating quotient for SUM_W-bit dividends
    function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] d);
        logic [RECIP_W-1:0] r;
        begin
            case (d)
                4'd1:    r = 21'd1048576;
                4'd2:    r = 21'd524288;
                4'd3:    r = 21'd349526;
                4'd4:    r = 21'd262144;
                4'd5:    r = 21'd209716;
                4'd6:    r = 21'd174763;
                4'd7:    r = 21'd149797;
                4'd8:    r = 21'd131072;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== design/three_channel_adc_smoothing_filter.sv =====
`timescale 1ns / 1ps
// Three-channel ADC smoothing filter: moving average and exponential average per channel.
// Depends on adcsf_pkg.
//
// One frame of three 12-bit samples goes in per word and one word of six 12-bit results
// comes out: three moving averages over the last eight frames (divided by the frame count
// until eight have arrived), then three exponential averages weighted by cfg_data (Q1.15,
// values above 32768 saturate). One frame is in flight at a time, so a new frame is taken
// only once the result of the last one has been loaded into the output register, which waits
// on the output side: the three channels pass in turn through a read, multiply and
// write-back pipeline around the per-channel state memory, and the sample ring is read at
// acceptance and written on the last write-back. Reset needs no clearing pass: valid bits
// mark ring rows and channel entries that hold data. Write cfg_data only while idle.
module three_channel_adc_smoothing_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adcsf_pkg::ALPHA_W-1:0]     cfg_data,   // smoothing_alpha
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_pot, sample_light, sample_temp, zero pad
    input  logic [adcsf_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // avg_pot, avg_light, avg_temp, ema_out_pot, ema_out_light, ema_out_temp
    output logic [adcsf_pkg::M_TDATA_W-1:0]   m_tdata
);
    import adcsf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                filled_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [SAMPLE_W-1:0] samp_reg [CHANNELS];

    logic [SAMPLE_W*CHANNELS-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W*CHANNELS-1:0] ring_q_reg;
    logic [WINDOW-1:0]            ring_vld_reg;
    logic                         ring_hit_reg;

    chan_entry_t         chan_mem [CHANNELS];
    chan_entry_t         chan_q_reg;
    logic [CHANNELS-1:0] chan_vld_reg;
    logic                chan_hit_reg;

    logic [SUM_W-1:0]    sum_m_reg;
    logic [PA_W-1:0]     pa_m_reg;
    logic [PL_W-1:0]     pl_m_reg;
    logic [PH_W-1:0]     ph_m_reg;
    logic [CH_W-1:0]     ch_m_reg;
    logic                start_m_reg;
    logic [SAMPLE_W-1:0] x_m_reg;

    logic [SAMPLE_W-1:0] avg_res_reg [CHANNELS];
    logic [SAMPLE_W-1:0] ema_res_reg [CHANNELS];

    logic                s_acc, m_load, mul_en, wb_en, last_wb;
    logic [CH_W-1:0]     rd_addr, ch_sel;
    logic [SAMPLE_W-1:0] x_cur, old_cur;
    chan_entry_t         entry_cur;
    logic [SUM_W-1:0]    sum_cur;
    logic [ALPHA_W-1:0]  beta;
    logic [TOT_W-1:0]    ema_sum;
    logic [EMA_W-1:0]    ema_new;
    logic [POS_W-1:0]    pos_inc;
    logic [COUNT_W-1:0]  count;
    logic [DIVP_W-1:0]   quot_prod;
    logic [SAMPLE_W*CHANNELS-1:0] ring_wr;
    logic [M_TDATA_W-1:0] m_pack;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign mul_en  = (state_reg == ST_RUN) && (step_reg < STEP_W'(CHANNELS));
    assign wb_en   = (state_reg == ST_RUN) && (step_reg != '0);
    assign last_wb = (state_reg == ST_RUN) && (step_reg == STEP_W'(CHANNELS));
    assign m_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        rd_addr = '0;
        if (state_reg == ST_RUN && step_reg < STEP_W'(CHANNELS - 1)) begin
            rd_addr = CH_W'(step_reg + 1'b1);
        end
    end

    // multiply stage operands
    always_comb begin
        ch_sel    = CH_W'(step_reg);
        x_cur     = samp_reg[ch_sel];
        old_cur   = ring_hit_reg ? ring_q_reg[ch_sel*SAMPLE_W +: SAMPLE_W] : '0;
        entry_cur = chan_hit_reg ? chan_q_reg : '0;
        sum_cur   = entry_cur.sum - SUM_W'(old_cur) + SUM_W'(x_cur);
        beta      = ALPHA_ONE - alpha_reg;
    end

    // write-back stage
    always_comb begin
        ema_sum = (TOT_W'(pa_m_reg) << EMA_FRAC) + (TOT_W'(ph_m_reg) << EMA_FRAC)
                + TOT_W'(pl_m_reg);
        ema_new = start_m_reg ? EMA_W'(ema_sum >> ALPHA_SH) : {x_m_reg, {EMA_FRAC{1'b0}}};
        pos_inc = pos_reg + 1'b1;
        count   = (filled_reg || pos_inc == '0) ? COUNT_W'(WINDOW) : COUNT_W'(pos_inc);
        quot_prod = DIVP_W'(sum_m_reg) * DIVP_W'(recip(count));
    end

    always_comb begin
        m_pack = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            ring_wr[c*SAMPLE_W +: SAMPLE_W] = samp_reg[c];
            m_pack[c*SAMPLE_W +: SAMPLE_W] = avg_res_reg[c];
            m_pack[(CHANNELS + c)*SAMPLE_W +: SAMPLE_W] = ema_res_reg[c];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (last_wb) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            alpha_reg    <= ALPHA_RESET;
            pos_reg      <= '0;
            filled_reg   <= 1'b0;
            ring_vld_reg <= '0;
            chan_vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                alpha_reg <= (cfg_data > ALPHA_ONE) ? ALPHA_ONE : cfg_data;
            end
            if (s_acc) begin
                step_reg <= '0;
            end else if (state_reg == ST_RUN) begin
                step_reg <= step_reg + 1'b1;
            end
            if (wb_en) begin
                chan_vld_reg[ch_m_reg] <= 1'b1;
            end
            if (last_wb) begin
                ring_vld_reg[pos_reg] <= 1'b1;
                pos_reg <= pos_inc;
                if (pos_inc == '0) filled_reg <= 1'b1;
            end
            if (m_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // memories and datapath
    always_ff @(posedge aclk) begin
        ring_q_reg   <= ring_mem[pos_reg];
        ring_hit_reg <= ring_vld_reg[pos_reg];
        chan_q_reg   <= chan_mem[rd_addr];
        chan_hit_reg <= chan_vld_reg[rd_addr];
        if (s_acc) begin
            for (int c = 0; c < CHANNELS; c++) begin
                samp_reg[c] <= s_tdata[c*SAMPLE_W +: SAMPLE_W];
            end
        end
        if (mul_en) begin
            sum_m_reg   <= sum_cur;
            pa_m_reg    <= PA_W'(alpha_reg) * PA_W'(x_cur);
            pl_m_reg    <= PL_W'(beta) * PL_W'(entry_cur.ema[EMA_FRAC-1:0]);
            ph_m_reg    <= PH_W'(beta) * PH_W'(entry_cur.ema[EMA_W-1:EMA_FRAC]);
            ch_m_reg    <= ch_sel;
            start_m_reg <= chan_hit_reg;
            x_m_reg     <= x_cur;
        end
        if (wb_en) begin
            chan_mem[ch_m_reg]    <= '{sum: sum_m_reg, ema: ema_new};
            avg_res_reg[ch_m_reg] <= quot_prod[RECIP_SH +: SAMPLE_W];
            ema_res_reg[ch_m_reg] <= ema_new[EMA_W-1:EMA_FRAC];
        end
        if (last_wb) begin
            ring_mem[pos_reg] <= ring_wr;
        end
        if (m_load) begin
            m_tdata_reg <= m_pack;
        end
    end

endmodule

// ===== design/adcsf_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the ADC smoothing filter, bound to the top level.
// Depends on adcsf_pkg and three_channel_adc_smoothing_filter.
module adcsf_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [adcsf_pkg::M_TDATA_W-1:0] m_tdata
);
    import adcsf_pkg::*;

    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second frame taken while one is in flight");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##6 m_tvalid)
        else $error("result word missing after accepted frame");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule

bind three_channel_adc_smoothing_filter adcsf_chk u_adcsf_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/three_channel_adc_smoothing_filter_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for three_channel_adc_smoothing_filter: directed frames, then random
// frames under several alpha settings, checked word by word against an in-bench predictor.
// Depends on adcsf_pkg and the filter top level.
module three_channel_adc_smoothing_filter_test;
    import adcsf_pkg::*;

    localparam int SETTLE     = 12;
    localparam int IDLE_LIMIT = 2000;
    localparam int NUM_FIELDS = 2 * CHANNELS;

    typedef logic [M_TDATA_W-1:0] smooth_word_t;
    typedef enum logic {ROW_FRAME, ROW_ALPHA} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [ALPHA_W-1:0]     alpha;
        logic [SAMPLE_W-1:0]    pot;
        logic [SAMPLE_W-1:0]    light;
        logic [SAMPLE_W-1:0]    temp;
        logic                   typed;
        smooth_word_t           want;
    } plan_row_t;

    typedef struct packed {
        logic         typed;
        smooth_word_t want;
    } frame_note_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [ALPHA_W-1:0]        cfg_data;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_W-1:0]      s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [M_TDATA_W-1:0]      m_tdata;

    // filter state as the predictor keeps it
    logic [SAMPLE_W-1:0]       ring_q [WINDOW][CHANNELS];
    int unsigned               ring_pos;
    logic                      ring_full;
    int unsigned               win_sum [CHANNELS];
    logic [47:0]               ema_acc [CHANNELS];
    logic                      ema_live [CHANNELS];
    logic [ALPHA_W-1:0]        alpha_q;

    smooth_word_t              smoothed_due [$];
    frame_note_t               frame_notes [$];
    int                        mismatches;
    int                        idle_cycles;
    int                        stretch_left [2];
    logic                      stretch_quiet [2];
    plan_row_t                 plan [22];
    string field_name [NUM_FIELDS] = '{"avg_pot", "avg_light", "avg_temp",
                                       "ema_out_pot", "ema_out_light", "ema_out_temp"};

    three_channel_adc_smoothing_filter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),    // smoothing_alpha
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // sample_pot, sample_light, sample_temp, zero pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)      // avg_pot, avg_light, avg_temp, ema_out_pot/light/temp
    );

    always #5 aclk = ~aclk;

    function automatic smooth_word_t smooth_frame(input logic [3*SAMPLE_W-1:0] frame);
        int unsigned         pos;
        int unsigned         nxt;
        int unsigned         divisor;
        logic [SAMPLE_W-1:0] x;
        logic [47:0]         xq;
        smooth_word_t        w;
        begin
            w = '0;
            pos = ring_pos;
            nxt = (pos + 1) % WINDOW;
            if (nxt == 0) ring_full = 1'b1;
            divisor = ring_full ? WINDOW : nxt;
            for (int c = 0; c < CHANNELS; c++) begin
                x  = frame[c*SAMPLE_W +: SAMPLE_W];
                xq = 48'(x) << EMA_FRAC;
                win_sum[c] = win_sum[c] - ring_q[pos][c] + x;
                ring_q[pos][c] = x;
                w[c*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(win_sum[c] / divisor);
                if (!ema_live[c]) begin
                    ema_acc[c]  = xq;
                    ema_live[c] = 1'b1;
                end else begin
                    ema_acc[c] = (48'(alpha_q) * xq
                                  + (48'(ALPHA_ONE) - 48'(alpha_q)) * ema_acc[c]) >> ALPHA_SH;
                end
                w[(CHANNELS+c)*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(ema_acc[c] >> EMA_FRAC);
            end
            ring_pos = nxt;
            return w;
        end
    endfunction

    // gaps come in stretches, some of them with no idling at all
    function automatic int draw_gap(input int side);
        begin
            if (stretch_left[side] == 0) begin
                stretch_left[side]  = $urandom_range(10, 60);
                stretch_quiet[side] = ($urandom_range(0, 3) == 0);
            end
            stretch_left[side]--;
            return stretch_quiet[side] ? 0 : $urandom_range(0, 17);
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        begin
            case ($urandom_range(0, 7))
                0:       return '0;
                1:       return '1;
                default: return SAMPLE_W'($urandom_range(0, 4095));
            endcase
        end
    endfunction

    task automatic send_frame(input logic [SAMPLE_W-1:0] pot, input logic [SAMPLE_W-1:0] light,
                              input logic [SAMPLE_W-1:0] temp, input logic typed,
                              input smooth_word_t want);
        int          gap;
        frame_note_t note;
        begin
            gap = draw_gap(0);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            note.typed = typed;
            note.want  = want;
            frame_notes.push_back(note);
            s_tdata  <= S_TDATA_W'({temp, light, pot});
            s_tvalid <= 1'b1;
            @(posedge aclk);
            while (!(s_tvalid && s_tready)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        begin
            s_tvalid <= 1'b0;
            while (frame_notes.size() != 0 || smoothed_due.size() != 0) @(posedge aclk);
            repeat (SETTLE) @(posedge aclk);
        end
    endtask

    task automatic write_alpha(input logic [ALPHA_W-1:0] value);
        begin
            cfg_data  <= value;
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!(cfg_valid && cfg_ready)) @(posedge aclk);
            cfg_valid <= 1'b0;
            alpha_q = (value > ALPHA_ONE) ? ALPHA_ONE : value;
        end
    endtask

    // result side
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap(1);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // predict on acceptance, check on delivery, watch for a stall
    always @(posedge aclk) begin
        frame_note_t  note;
        smooth_word_t pred;
        smooth_word_t due;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred = smooth_frame(s_tdata[3*SAMPLE_W-1:0]);
                if (frame_notes.size() == 0) begin
                    $display("%0t: word accepted with no frame sent", $time);
                    mismatches++;
                    smoothed_due.push_back(pred);
                end else begin
                    note = frame_notes.pop_front();
                    smoothed_due.push_back(note.typed ? note.want : pred);
                end
            end
            if (m_tvalid && m_tready) begin
                if (smoothed_due.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    due = smoothed_due.pop_front();
                    for (int f = 0; f < NUM_FIELDS; f++) begin
                        if (m_tdata[f*SAMPLE_W +: SAMPLE_W] !== due[f*SAMPLE_W +: SAMPLE_W]) begin
                            $display("%0t: %s expected %0d, actual %0d", $time, field_name[f],
                                     due[f*SAMPLE_W +: SAMPLE_W],
                                     m_tdata[f*SAMPLE_W +: SAMPLE_W]);
                            mismatches++;
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int                  n_frames;
        logic [ALPHA_W-1:0]  alpha;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        mismatches  = 0;
        idle_cycles = 0;
        stretch_left[0] = 0;
        stretch_left[1] = 0;
        ring_pos  = 0;
        ring_full = 1'b0;
        alpha_q   = ALPHA_RESET;
        for (int c = 0; c < CHANNELS; c++) begin
            win_sum[c]  = 0;
            ema_acc[c]  = '0;
            ema_live[c] = 1'b0;
            for (int r = 0; r < WINDOW; r++) ring_q[r][c] = '0;
        end

        // first frame loads both filters directly
        plan[0]  = '{ROW_FRAME, 16'd0, 12'd4095, 12'd0, 12'd2048, 1'b1,
                     {12'd2048, 12'd0, 12'd4095, 12'd2048, 12'd0, 12'd4095}};
        plan[1]  = '{ROW_FRAME, 16'd0, 12'd0, 12'd4095, 12'd2048, 1'b0, '0};
        plan[2]  = '{ROW_FRAME, 16'd0, 12'd1, 12'd2, 12'd4094, 1'b0, '0};
        plan[3]  = '{ROW_FRAME, 16'd0, 12'd2048, 12'd2047, 12'd0, 1'b0, '0};
        plan[4]  = '{ROW_FRAME, 16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0};
        plan[5]  = '{ROW_FRAME, 16'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0};
        plan[6]  = '{ROW_FRAME, 16'd0, 12'd1365, 12'd2730, 12'd3, 1'b0, '0};
        plan[7]  = '{ROW_FRAME, 16'd0, 12'd4094, 12'd1, 12'd4095, 1'b0, '0};
        plan[8]  = '{ROW_FRAME, 16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0};
        plan[9]  = '{ROW_ALPHA, 16'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0};
        plan[10] = '{ROW_FRAME, 16'd0, 12'd0, 12'd4095, 12'd17, 1'b0, '0};
        plan[11] = '{ROW_FRAME, 16'd0, 12'd4095, 12'd0, 12'd4000, 1'b0, '0};
        plan[12] = '{ROW_ALPHA, 16'd32768, 12'd0, 12'd0, 12'd0, 1'b0, '0};
        plan[13] = '{ROW_FRAME, 16'd0, 12'd123, 12'd4095, 12'd0, 1'b0, '0};
        plan[14] = '{ROW_ALPHA, 16'd65535, 12'd0, 12'd0, 12'd0, 1'b0, '0};
        plan[15] = '{ROW_FRAME, 16'd0, 12'd4095, 12'd0, 12'd2048, 1'b0, '0};
        plan[16] = '{ROW_ALPHA, 16'd32769, 12'd0, 12'd0, 12'd0, 1'b0, '0};
        plan[17] = '{ROW_FRAME, 16'd0, 12'd0, 12'd4095, 12'd1, 1'b0, '0};
        plan[18] = '{ROW_ALPHA, 16'd1, 12'd0, 12'd0, 12'd0, 1'b0, '0};
        plan[19] = '{ROW_FRAME, 16'd0, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0};
        plan[20] = '{ROW_ALPHA, 16'd3277, 12'd0, 12'd0, 12'd0, 1'b0, '0};
        plan[21] = '{ROW_FRAME, 16'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_ALPHA) begin
                drain();
                write_alpha(plan[i].alpha);
            end else begin
                send_frame(plan[i].pot, plan[i].light, plan[i].temp, plan[i].typed,
                           plan[i].want);
            end
        end

        for (int phase = 0; phase < 10; phase++) begin
            drain();
            case ($urandom_range(0, 5))
                0:       alpha = '0;
                1:       alpha = ALPHA_ONE;
                2:       alpha = '1;
                3:       alpha = 16'd1;
                4:       alpha = ALPHA_W'($urandom_range(0, 32768));
                default: alpha = ALPHA_W'($urandom_range(0, 65535));
            endcase
            write_alpha(alpha);
            n_frames = $urandom_range(160, 190);
            for (int k = 0; k < n_frames; k++)
                send_frame(draw_sample(), draw_sample(), draw_sample(), 1'b0, '0);
        end

        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
